[src/assert_macros.svh]
// Assertion macros for the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

[src/tsic_pkg.sv]
// Constants and register codes for the touch swipe idle controller.
package tsic_pkg;

    localparam int ADDR_W      = 5;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 16;
    localparam int TIMEOUT_W   = 9;
    localparam int BRIGHT_W    = 7;
    localparam int DIST_W      = 10;
    localparam int HOLD_W      = 16;
    localparam int COORD_W     = 10;
    localparam int TIME_W      = 32;
    localparam int PAGE_W      = 4;
    localparam int TIMEOUT_MS_W = 19;

    localparam logic [2:0] REG_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_BRIGHT  = 3'd1;
    localparam logic [2:0] REG_SWIPE   = 3'd2;
    localparam logic [2:0] REG_MOVE    = 3'd3;
    localparam logic [2:0] REG_HOLD    = 3'd4;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MIN   = 9'd5;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX   = 9'd300;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 9'd30;
    localparam logic [BRIGHT_W-1:0]  BRIGHT_MIN    = 7'd10;
    localparam logic [BRIGHT_W-1:0]  BRIGHT_MAX    = 7'd100;
    localparam logic [BRIGHT_W-1:0]  BRIGHT_RESET  = 7'd80;
    localparam logic [DIST_W-1:0]    SWIPE_RESET   = 10'd50;
    localparam logic [DIST_W-1:0]    MOVE_RESET    = 10'd10;
    localparam logic [HOLD_W-1:0]    HOLD_RESET    = 16'd300;
    localparam logic [TIMEOUT_MS_W-1:0] MS_PER_S   = 19'd1000;

endpackage

[src/touch_swipe_idle_controller.sv]
// Touch swipe idle controller: screen blanking, wake and page swipe detection.
//
// Usage:
//   Input stream s_t*: one touch poll per item (pressed, x, y, millisecond time).
//   Result stream m_t*: one result per poll (screen state, brightness, page,
//   page change and swiping flags), in poll order.
//   APB port: five settings registers at byte addresses 0, 4, 8, 12, 16;
//   write them only while no poll is in flight.
// Throughput: one item per cycle unless the result stream stalls; the input
//   register feeds one pass of compare and subtract logic that updates the
//   gesture state and loads the result register in the same cycle.
// Reset: screen lit, first page, no gesture, registers at their defaults.
// Stall: while m_tready is low the result register holds; one more item waits
//   in the input register, after which s_tready drops until the result moves.
`include "assert_macros.svh"

module touch_swipe_idle_controller #(
    parameter int NUM_PAGES = 3
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pressed[0], touch_x[10:1], touch_y[20:11], now_ms[52:21], zero[55:53]
    input  logic [tsic_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // screen_on[0], brightness[7:1], page[11:8], page_changed[12],
    // swiping[13], zero[15:14]
    output logic [tsic_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tsic_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam logic [tsic_pkg::PAGE_W-1:0] PAGE_LAST = tsic_pkg::PAGE_W'(NUM_PAGES - 1);

    logic [tsic_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic [tsic_pkg::BRIGHT_W-1:0]  bright_reg;
    logic [tsic_pkg::DIST_W-1:0]    swipe_dist_reg;
    logic [tsic_pkg::DIST_W-1:0]    move_dist_reg;
    logic [tsic_pkg::HOLD_W-1:0]    hold_reg;
    logic                           cfg_wr;

    logic                           in_valid_reg;
    logic                           in_pressed_reg;
    logic [tsic_pkg::COORD_W-1:0]   in_x_reg;
    logic [tsic_pkg::COORD_W-1:0]   in_y_reg;
    logic [tsic_pkg::TIME_W-1:0]    in_now_reg;
    logic                           advance;

    logic                           blanked_reg, blanked_next;
    logic [tsic_pkg::TIME_W-1:0]    last_act_reg, last_act_next;
    logic                           start_valid_reg, start_valid_next;
    logic [tsic_pkg::COORD_W-1:0]   start_x_reg, start_x_next;
    logic [tsic_pkg::COORD_W-1:0]   start_y_reg, start_y_next;
    logic                           prev_pressed_reg, prev_pressed_next;
    logic                           swipe_reg, swipe_next;
    logic                           clear_pend_reg, clear_pend_next;
    logic [tsic_pkg::TIME_W-1:0]    clear_stamp_reg, clear_stamp_next;
    logic [tsic_pkg::PAGE_W-1:0]    page_reg, page_next;
    logic                           changed_next;

    logic                           out_valid_reg;
    logic                           out_screen_reg;
    logic [tsic_pkg::BRIGHT_W-1:0]  out_bright_reg;
    logic [tsic_pkg::PAGE_W-1:0]    out_page_reg;
    logic                           out_changed_reg;
    logic                           out_swipe_reg;

    logic [tsic_pkg::TIMEOUT_W-1:0]    timeout_clamped;
    logic [tsic_pkg::TIMEOUT_MS_W-1:0] timeout_ms;
    logic [tsic_pkg::BRIGHT_W-1:0]     bright_clamped;
    logic [tsic_pkg::TIME_W-1:0]       idle_elapsed;
    logic [tsic_pkg::TIME_W-1:0]       hold_elapsed;
    logic [tsic_pkg::COORD_W:0]        x_ext, sx_ext, sd_ext;
    logic                              move_left, move_right, moved;
    logic [tsic_pkg::COORD_W-1:0]      adx, ady;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= tsic_pkg::TIMEOUT_RESET;
            bright_reg     <= tsic_pkg::BRIGHT_RESET;
            swipe_dist_reg <= tsic_pkg::SWIPE_RESET;
            move_dist_reg  <= tsic_pkg::MOVE_RESET;
            hold_reg       <= tsic_pkg::HOLD_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                tsic_pkg::REG_TIMEOUT: timeout_reg    <= pwdata[tsic_pkg::TIMEOUT_W-1:0];
                tsic_pkg::REG_BRIGHT:  bright_reg     <= pwdata[tsic_pkg::BRIGHT_W-1:0];
                tsic_pkg::REG_SWIPE:   swipe_dist_reg <= pwdata[tsic_pkg::DIST_W-1:0];
                tsic_pkg::REG_MOVE:    move_dist_reg  <= pwdata[tsic_pkg::DIST_W-1:0];
                tsic_pkg::REG_HOLD:    hold_reg       <= pwdata[tsic_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            tsic_pkg::REG_TIMEOUT: prdata = 32'(timeout_reg);
            tsic_pkg::REG_BRIGHT:  prdata = 32'(bright_reg);
            tsic_pkg::REG_SWIPE:   prdata = 32'(swipe_dist_reg);
            tsic_pkg::REG_MOVE:    prdata = 32'(move_dist_reg);
            tsic_pkg::REG_HOLD:    prdata = 32'(hold_reg);
            default:               prdata = 32'd0;
        endcase
    end

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_swipe_reg, out_changed_reg, out_page_reg,
                       out_bright_reg, out_screen_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_pressed_reg <= s_tdata[0];
            in_x_reg       <= s_tdata[10:1];
            in_y_reg       <= s_tdata[20:11];
            in_now_reg     <= s_tdata[52:21];
        end
        if (advance) begin
            out_screen_reg  <= !blanked_next;
            out_bright_reg  <= blanked_next ? '0 : bright_clamped;
            out_page_reg    <= page_next;
            out_changed_reg <= changed_next;
            out_swipe_reg   <= swipe_next;
        end
    end

    // per-poll logic
    always_comb begin
        timeout_clamped = timeout_reg;
        if (timeout_reg < tsic_pkg::TIMEOUT_MIN) timeout_clamped = tsic_pkg::TIMEOUT_MIN;
        if (timeout_reg > tsic_pkg::TIMEOUT_MAX) timeout_clamped = tsic_pkg::TIMEOUT_MAX;
        bright_clamped = bright_reg;
        if (bright_reg < tsic_pkg::BRIGHT_MIN) bright_clamped = tsic_pkg::BRIGHT_MIN;
        if (bright_reg > tsic_pkg::BRIGHT_MAX) bright_clamped = tsic_pkg::BRIGHT_MAX;
    end

    assign timeout_ms   = tsic_pkg::TIMEOUT_MS_W'(timeout_clamped) * tsic_pkg::MS_PER_S;
    assign idle_elapsed = in_now_reg - last_act_reg;
    assign hold_elapsed = in_now_reg - clear_stamp_reg;

    assign x_ext      = {1'b0, in_x_reg};
    assign sx_ext     = {1'b0, start_x_reg};
    assign sd_ext     = {1'b0, swipe_dist_reg};
    assign move_left  = sx_ext > (x_ext + sd_ext);
    assign move_right = x_ext > (sx_ext + sd_ext);
    assign adx   = (in_x_reg >= start_x_reg) ? in_x_reg - start_x_reg : start_x_reg - in_x_reg;
    assign ady   = (in_y_reg >= start_y_reg) ? in_y_reg - start_y_reg : start_y_reg - in_y_reg;
    assign moved = (adx > move_dist_reg) || (ady > move_dist_reg);

    always_comb begin
        blanked_next      = blanked_reg;
        last_act_next     = last_act_reg;
        start_valid_next  = start_valid_reg;
        start_x_next      = start_x_reg;
        start_y_next      = start_y_reg;
        prev_pressed_next = prev_pressed_reg;
        swipe_next        = swipe_reg;
        clear_pend_next   = clear_pend_reg;
        clear_stamp_next  = clear_stamp_reg;
        page_next         = page_reg;
        changed_next      = 1'b0;

        if (clear_pend_reg && (hold_elapsed >= tsic_pkg::TIME_W'(hold_reg))) begin
            swipe_next      = 1'b0;
            clear_pend_next = 1'b0;
        end

        if (blanked_reg) begin
            if (in_pressed_reg) begin
                blanked_next     = 1'b0;
                last_act_next    = in_now_reg;
                start_x_next     = in_x_reg;
                start_y_next     = in_y_reg;
                start_valid_next = 1'b1;
                swipe_next       = 1'b0;
                clear_pend_next  = 1'b0;
            end
            prev_pressed_next = in_pressed_reg;
        end else if (!in_pressed_reg
                     && (idle_elapsed >= tsic_pkg::TIME_W'(timeout_ms))) begin
            blanked_next      = 1'b1;
            prev_pressed_next = 1'b0;
        end else begin
            if (in_pressed_reg) begin
                last_act_next = in_now_reg;
            end
            if (in_pressed_reg && !prev_pressed_reg) begin
                start_x_next     = in_x_reg;
                start_y_next     = in_y_reg;
                start_valid_next = 1'b1;
                swipe_next       = 1'b0;
                clear_pend_next  = 1'b0;
            end else if (!in_pressed_reg && prev_pressed_reg) begin
                if (start_valid_reg) begin
                    if (move_left && (page_reg < PAGE_LAST)) begin
                        page_next    = page_reg + 1'b1;
                        changed_next = 1'b1;
                        swipe_next   = 1'b1;
                    end else if (move_right && (page_reg != '0)) begin
                        page_next    = page_reg - 1'b1;
                        changed_next = 1'b1;
                        swipe_next   = 1'b1;
                    end else if (moved) begin
                        swipe_next = 1'b1;
                    end
                end
                start_valid_next = 1'b0;
                if (swipe_next) begin
                    clear_pend_next  = 1'b1;
                    clear_stamp_next = in_now_reg;
                end
            end
            prev_pressed_next = in_pressed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blanked_reg      <= 1'b0;
            last_act_reg     <= '0;
            start_valid_reg  <= 1'b0;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            prev_pressed_reg <= 1'b0;
            swipe_reg        <= 1'b0;
            clear_pend_reg   <= 1'b0;
            clear_stamp_reg  <= '0;
            page_reg         <= '0;
        end else if (advance) begin
            blanked_reg      <= blanked_next;
            last_act_reg     <= last_act_next;
            start_valid_reg  <= start_valid_next;
            start_x_reg      <= start_x_next;
            start_y_reg      <= start_y_next;
            prev_pressed_reg <= prev_pressed_next;
            swipe_reg        <= swipe_next;
            clear_pend_reg   <= clear_pend_next;
            clear_stamp_reg  <= clear_stamp_next;
            page_reg         <= page_next;
        end
    end

    `ASSERT_PROP(a_bright_tracks_screen, aclk, aresetn,
        out_valid_reg |-> (out_screen_reg == (out_bright_reg != '0)))
    `ASSERT_PROP(a_change_sets_swipe, aclk, aresetn,
        (out_valid_reg && out_changed_reg) |-> out_swipe_reg)
    `ASSERT_NEVER(a_page_in_range, aclk, aresetn, page_reg > PAGE_LAST)
    `ASSERT_PROP(a_page_moves_reported, aclk, aresetn,
        (page_reg != $past(page_reg)) |-> (out_valid_reg && out_changed_reg))
    `ASSERT_PROP(a_blank_clears_press, aclk, aresetn,
        $rose(blanked_reg) |-> !prev_pressed_reg)

endmodule

[verif/tb_touch_swipe_idle_controller.sv]
`timescale 1ns / 1ps
// Testbench for the touch swipe idle controller: directed and random polls against a local model.
module tb_touch_swipe_idle_controller;

    localparam int PAGES = 3;

    typedef struct {
        logic                         pressed;
        logic [tsic_pkg::COORD_W-1:0] x;
        logic [tsic_pkg::COORD_W-1:0] y;
        logic [tsic_pkg::TIME_W-1:0]  now;
    } poll_t;

    typedef struct {
        logic                          screen_on;
        logic [tsic_pkg::BRIGHT_W-1:0] brightness;
        logic [tsic_pkg::PAGE_W-1:0]   page;
        logic                          page_changed;
        logic                          swiping;
    } status_t;

    logic                            aclk;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tsic_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tsic_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [tsic_pkg::ADDR_W-1:0]     paddr    = '0;
    logic [31:0]                     pwdata   = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    touch_swipe_idle_controller #(.NUM_PAGES(PAGES)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // settings and gesture state as the block should hold them
    logic [tsic_pkg::TIMEOUT_W-1:0] cfg_timeout;
    logic [tsic_pkg::BRIGHT_W-1:0]  cfg_bright;
    logic [tsic_pkg::DIST_W-1:0]    cfg_swipe;
    logic [tsic_pkg::DIST_W-1:0]    cfg_move;
    logic [tsic_pkg::HOLD_W-1:0]    cfg_hold;
    logic                           blanked;
    logic                           start_valid;
    logic                           was_pressed;
    logic                           swipe_on;
    logic                           hold_pending;
    logic [tsic_pkg::TIME_W-1:0]    last_touch;
    logic [tsic_pkg::TIME_W-1:0]    hold_stamp;
    logic [tsic_pkg::COORD_W-1:0]   start_x;
    logic [tsic_pkg::COORD_W-1:0]   start_y;
    logic [tsic_pkg::PAGE_W-1:0]    page_idx;

    status_t                     status_q[$];
    int                          errors     = 0;
    int                          polls_sent = 0;
    int                          hold_req   = 0;
    logic                        send_gaps  = 1'b1;
    logic                        ready_gaps = 1'b1;
    logic [tsic_pkg::TIME_W-1:0] clock_ms   = '0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [tsic_pkg::TIME_W-1:0] timeout_ms();
        logic [tsic_pkg::TIME_W-1:0] secs;
        secs = cfg_timeout;
        if (secs < tsic_pkg::TIMEOUT_MIN) secs = tsic_pkg::TIMEOUT_MIN;
        if (secs > tsic_pkg::TIMEOUT_MAX) secs = tsic_pkg::TIMEOUT_MAX;
        return secs * tsic_pkg::MS_PER_S;
    endfunction

    function automatic logic [tsic_pkg::BRIGHT_W-1:0] lit_level();
        logic [tsic_pkg::BRIGHT_W-1:0] lvl;
        lvl = cfg_bright;
        if (lvl < tsic_pkg::BRIGHT_MIN) lvl = tsic_pkg::BRIGHT_MIN;
        if (lvl > tsic_pkg::BRIGHT_MAX) lvl = tsic_pkg::BRIGHT_MAX;
        return lvl;
    endfunction

    function automatic logic [tsic_pkg::COORD_W-1:0] clip(input int v);
        if (v < 0) return '0;
        if (v > 1023) return 10'd1023;
        return tsic_pkg::COORD_W'(v);
    endfunction

    // advance that puts the next poll at timeout + delta after the last press
    function automatic logic [tsic_pkg::TIME_W-1:0] idle_gap(input int delta);
        return last_touch + timeout_ms() + tsic_pkg::TIME_W'(delta) - clock_ms;
    endfunction

    function automatic logic [tsic_pkg::TIME_W-1:0] hold_step();
        case ($urandom_range(4))
            0: return tsic_pkg::TIME_W'(cfg_hold) - 1;
            1: return tsic_pkg::TIME_W'(cfg_hold);
            2: return tsic_pkg::TIME_W'(cfg_hold) + 1;
            3: return $urandom_range(20);
            default: return $urandom_range(2000);
        endcase
    endfunction

    task automatic reset_model();
        cfg_timeout  = tsic_pkg::TIMEOUT_RESET;
        cfg_bright   = tsic_pkg::BRIGHT_RESET;
        cfg_swipe    = tsic_pkg::SWIPE_RESET;
        cfg_move     = tsic_pkg::MOVE_RESET;
        cfg_hold     = tsic_pkg::HOLD_RESET;
        blanked      = 1'b0;
        start_valid  = 1'b0;
        was_pressed  = 1'b0;
        swipe_on     = 1'b0;
        hold_pending = 1'b0;
        last_touch   = '0;
        hold_stamp   = '0;
        start_x      = '0;
        start_y      = '0;
        page_idx     = '0;
    endtask

    task automatic start_touch(input logic [tsic_pkg::COORD_W-1:0] x,
                               input logic [tsic_pkg::COORD_W-1:0] y);
        start_x      = x;
        start_y      = y;
        start_valid  = 1'b1;
        swipe_on     = 1'b0;
        hold_pending = 1'b0;
    endtask

    task automatic track_poll(input poll_t p, output status_t r);
        logic                        changed;
        logic [tsic_pkg::TIME_W-1:0] since_release;
        logic [tsic_pkg::TIME_W-1:0] idle;
        int                          xi, yi, sxi, syi, dx, dy, adx, ady, sd, md;
        changed = 1'b0;
        since_release = p.now - hold_stamp;
        if (hold_pending && since_release >= tsic_pkg::TIME_W'(cfg_hold)) begin
            swipe_on     = 1'b0;
            hold_pending = 1'b0;
        end
        idle = p.now - last_touch;
        if (blanked) begin
            if (p.pressed) begin
                blanked    = 1'b0;
                last_touch = p.now;
                start_touch(p.x, p.y);
            end
            was_pressed = p.pressed;
        end else if (!p.pressed && idle >= timeout_ms()) begin
            blanked     = 1'b1;
            was_pressed = 1'b0;
        end else begin
            if (p.pressed) last_touch = p.now;
            if (p.pressed && !was_pressed) begin
                start_touch(p.x, p.y);
            end else if (!p.pressed && was_pressed) begin
                if (start_valid) begin
                    xi  = p.x;
                    yi  = p.y;
                    sxi = start_x;
                    syi = start_y;
                    sd  = cfg_swipe;
                    md  = cfg_move;
                    dx  = xi - sxi;
                    dy  = yi - syi;
                    adx = dx < 0 ? -dx : dx;
                    ady = dy < 0 ? -dy : dy;
                    if (dx < -sd && int'(page_idx) + 1 < PAGES) begin
                        page_idx = page_idx + 1'b1;
                        changed  = 1'b1;
                        swipe_on = 1'b1;
                    end else if (dx > sd && page_idx > 0) begin
                        page_idx = page_idx - 1'b1;
                        changed  = 1'b1;
                        swipe_on = 1'b1;
                    end else if (adx > md || ady > md) begin
                        swipe_on = 1'b1;
                    end
                end
                start_valid = 1'b0;
                if (swipe_on) begin
                    hold_pending = 1'b1;
                    hold_stamp   = p.now;
                end
            end
            was_pressed = p.pressed;
        end
        r.screen_on    = !blanked;
        r.brightness   = blanked ? '0 : lit_level();
        r.page         = page_idx;
        r.page_changed = changed;
        r.swiping      = swipe_on;
    endtask

    // starts and ends at a falling edge; valid stays high for a following item
    task automatic send_poll(input poll_t p);
        status_t r;
        while (send_gaps && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, p.now, p.y, p.x, p.pressed};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_poll(p, r);
        status_q.push_back(r);
        polls_sent++;
        @(negedge aclk);
    endtask

    task automatic touch_poll(input logic pr, input int x, input int y,
                              input logic [tsic_pkg::TIME_W-1:0] adv);
        poll_t p;
        clock_ms  = clock_ms + adv;
        p.pressed = pr;
        p.x       = clip(x);
        p.y       = clip(y);
        p.now     = clock_ms;
        send_poll(p);
    endtask

    // drop valid and hold until every result is back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (status_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            tsic_pkg::REG_TIMEOUT: cfg_timeout = value[tsic_pkg::TIMEOUT_W-1:0];
            tsic_pkg::REG_BRIGHT:  cfg_bright  = value[tsic_pkg::BRIGHT_W-1:0];
            tsic_pkg::REG_SWIPE:   cfg_swipe   = value[tsic_pkg::DIST_W-1:0];
            tsic_pkg::REG_MOVE:    cfg_move    = value[tsic_pkg::DIST_W-1:0];
            tsic_pkg::REG_HOLD:    cfg_hold    = value[tsic_pkg::HOLD_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_config(input int tmo, input int bright, input int swipe,
                                input int move, input int hold);
        write_reg(tsic_pkg::REG_TIMEOUT, tmo);
        write_reg(tsic_pkg::REG_BRIGHT, bright);
        write_reg(tsic_pkg::REG_SWIPE, swipe);
        write_reg(tsic_pkg::REG_MOVE, move);
        write_reg(tsic_pkg::REG_HOLD, hold);
    endtask

    task automatic pick_stroke(output int sx, output int sy, output int ex, output int ey);
        int dir, sd, md;
        dir = $urandom_range(2);
        sd  = cfg_swipe;
        md  = cfg_move;
        sy  = $urandom_range(1023);
        if (dir == 0 && sd < 1022) begin
            sx = $urandom_range(1023, sd + 1);
            ex = $urandom_range(sx - sd - 1, 0);
            ey = sy + $urandom_range(40) - 20;
        end else if (dir == 1 && sd < 1022) begin
            sx = $urandom_range(1022 - sd, 0);
            ex = $urandom_range(1023, sx + sd + 1);
            ey = sy + $urandom_range(40) - 20;
        end else begin
            sx = $urandom_range(1023);
            ex = sx + $urandom_range(2 * md + 2) - md - 1;
            ey = sy + $urandom_range(2 * md + 2) - md - 1;
        end
    endtask

    task automatic run_sessions(input int count);
        int goal, kind, sx, sy, ex, ey;
        goal = polls_sent + count;
        while (polls_sent < goal) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                pick_stroke(sx, sy, ex, ey);
                touch_poll(1'b1, sx, sy, $urandom_range(40, 1));
                repeat ($urandom_range(3))
                    touch_poll(1'b1, $urandom_range(1023), $urandom_range(1023),
                               $urandom_range(40, 1));
                touch_poll(1'b0, ex, ey, $urandom_range(40, 1));
                repeat ($urandom_range(3))
                    touch_poll(1'b0, $urandom_range(1023), $urandom_range(1023), hold_step());
            end else if (kind < 78) begin
                if (!blanked) begin
                    touch_poll(1'b0, $urandom_range(1023), $urandom_range(1023), idle_gap(-1));
                    touch_poll(1'b0, $urandom_range(1023), $urandom_range(1023),
                               $urandom_range(3, 1));
                end
                repeat ($urandom_range(2))
                    touch_poll(1'b0, $urandom_range(1023), $urandom_range(1023),
                               $urandom_range(5000));
                pick_stroke(sx, sy, ex, ey);
                touch_poll(1'b1, sx, sy, $urandom_range(100, 1));
                touch_poll(1'b0, ex, ey, $urandom_range(40, 1));
            end else if (kind < 90) begin
                clock_ms = $urandom;
                touch_poll($urandom_range(1), $urandom_range(1023), $urandom_range(1023), 0);
            end else begin
                // long press past the timeout, then a second release with no start
                touch_poll(1'b1, $urandom_range(1023), $urandom_range(1023), 10);
                touch_poll(1'b1, $urandom_range(1023), $urandom_range(1023),
                           timeout_ms() + $urandom_range(500));
                touch_poll(1'b0, $urandom_range(1023), $urandom_range(1023), 10);
                touch_poll(1'b0, $urandom_range(1023), $urandom_range(1023), 10);
            end
        end
    endtask

    task automatic test_directed();
        // release with no start recorded
        touch_poll(1'b0, 0, 0, 0);
        // leftward swipe across the panel
        touch_poll(1'b1, 1023, 1023, 100);
        touch_poll(1'b1, 600, 1023, 20);
        touch_poll(1'b0, 0, 1023, 20);
        // hold expiry: one short, then exactly at the hold
        touch_poll(1'b0, 0, 0, 299);
        touch_poll(1'b0, 0, 0, 1);
        // rightward swipe back to the first page
        touch_poll(1'b1, 0, 0, 50);
        touch_poll(1'b0, 1023, 0, 20);
        // rightward swipe at the first page
        touch_poll(1'b1, 0, 512, 400);
        touch_poll(1'b0, 1023, 512, 20);
        // tap, then a vertical move beyond the move distance
        touch_poll(1'b1, 500, 500, 10);
        touch_poll(1'b0, 505, 505, 20);
        touch_poll(1'b1, 500, 500, 400);
        touch_poll(1'b0, 500, 520, 20);
        // walk to the last page and past it
        repeat (3) begin
            touch_poll(1'b1, 900, 0, 400);
            touch_poll(1'b0, 100, 0, 20);
        end
        // idle one short of the timeout, then blank, stay blank, wake
        touch_poll(1'b0, 0, 0, idle_gap(-1));
        touch_poll(1'b0, 0, 0, 1);
        touch_poll(1'b0, 0, 0, 5000);
        touch_poll(1'b1, 800, 10, 10);
        touch_poll(1'b0, 700, 10, 20);
        // time wrap through the all-ones timestamp
        clock_ms = 32'hFFFF_FFFE;
        touch_poll(1'b1, 0, 1023, 1);
        touch_poll(1'b0, 1023, 1023, 1);
        settle();
    endtask

    task automatic test_register_extremes();
        apply_config(0, 0, 1, 0, 0);
        run_sessions(150);
        settle();
        apply_config(511, 127, 1023, 1023, 16'hFFFF);
        run_sessions(150);
        settle();
        apply_config(tsic_pkg::TIMEOUT_MIN, tsic_pkg::BRIGHT_MAX, 0, 1023, 1);
        run_sessions(40);
        settle();
    endtask

    task automatic test_random_settings();
        repeat (10) begin
            apply_config($urandom_range(99) < 80 ? $urandom_range(40) : $urandom_range(511),
                         $urandom_range(127),
                         $urandom_range(99) < 80 ? $urandom_range(300) : $urandom_range(1023),
                         $urandom_range(99) < 80 ? $urandom_range(60) : $urandom_range(1023),
                         $urandom_range(99) < 70 ? $urandom_range(1000) : $urandom_range(65535));
            run_sessions(125);
            settle();
        end
    endtask

    task automatic test_backpressure();
        send_gaps = 1'b0;
        hold_req  = 80;
        run_sessions(40);
        send_gaps = 1'b1;
        settle();
    endtask

    task automatic test_no_gaps();
        send_gaps  = 1'b0;
        ready_gaps = 1'b0;
        run_sessions(200);
        send_gaps  = 1'b1;
        ready_gaps = 1'b1;
        settle();
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= !(ready_gaps && $urandom_range(99) < 20);
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_q.size() == 0) begin
                $error("result with no poll pending: %h", m_tdata);
                errors++;
            end else begin
                want = status_q.pop_front();
                check_field("screen_on", want.screen_on, m_tdata[0]);
                check_field("brightness", want.brightness, m_tdata[7:1]);
                check_field("page", want.page, m_tdata[11:8]);
                check_field("page_changed", want.page_changed, m_tdata[12]);
                check_field("swiping", want.swiping, m_tdata[13]);
            end
        end
    end

    initial begin
        reset_model();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_register_extremes();
        test_random_settings();
        test_backpressure();
        test_no_gaps();
        settle();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
